// ===== design/rari_pkg.sv =====
`timescale 1ns / 1ps

package rari_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
  localparam int SHR_WIDTH   = PROD_WIDTH - FRAC_BITS;
  localparam int UV_WIDTH    = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [UV_WIDTH-1:0] UV_ONE = UV_WIDTH'(65536);

  // pipeline map: five compute stages, one divider setup plus one stage per
  // quotient bit, then the output register
  localparam int ST_S1    = 0;
  localparam int ST_S2    = 1;
  localparam int ST_S3    = 2;
  localparam int ST_S4    = 3;
  localparam int ST_S5    = 4;
  localparam int ST_DIV0  = 5;
  localparam int DIV_LAST = UV_WIDTH;
  localparam int ST_OUT   = ST_DIV0 + DIV_LAST + 1;
  localparam int NUM_ST   = ST_OUT + 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef enum logic [1:0] {
    MODE_XY = 2'd0,
    MODE_XZ = 2'd1,
    MODE_YZ = 2'd2
  } plane_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_MODE   = 3'd0,
    REG_PLANE_OFFSET = 3'd1,
    REG_LOW_A        = 3'd2,
    REG_HIGH_A       = 3'd3,
    REG_LOW_B        = 3'd4,
    REG_HIGH_B       = 3'd5,
    REG_REVERSE      = 3'd6,
    REG_TWO_SIDED    = 3'd7
  } reg_idx_t;

  localparam coord_t CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic                  hit;
    coord_t                t;
    coord_t                pa;
    coord_t                pb;
    logic                  dn_nonneg;
    logic [COORD_WIDTH:0]  rem_u;
    logic [COORD_WIDTH:0]  rem_v;
    logic [COORD_WIDTH-1:0] span_u;
    logic [COORD_WIDTH-1:0] span_v;
    logic [UV_WIDTH-1:0]   q_u;
    logic [UV_WIDTH-1:0]   q_v;
  } div_t;

  // saturate a signed value one bit wider than a coordinate
  function automatic coord_t sat1(logic signed [COORD_WIDTH:0] x);
    coord_t r;
    if (x[COORD_WIDTH] != x[COORD_WIDTH-1]) begin
      r = x[COORD_WIDTH] ? CMIN : CMAX;
    end else begin
      r = x[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic coord_t sat_add(coord_t a, coord_t b);
    logic signed [COORD_WIDTH:0] s;
    s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
    return sat1(s);
  endfunction

  function automatic coord_t sat_sub(coord_t a, coord_t b);
    logic signed [COORD_WIDTH:0] s;
    s = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
    return sat1(s);
  endfunction

  // fixed-point rescale of a full product: truncate toward zero, saturate
  function automatic coord_t qsat(logic signed [PROD_WIDTH-1:0] p);
    logic signed [PROD_WIDTH-1:0] adj;
    logic signed [SHR_WIDTH-1:0]  sh;
    coord_t r;
    adj = p + (p[PROD_WIDTH-1] ? PROD_WIDTH'((64'd1 << FRAC_BITS) - 64'd1)
                               : {PROD_WIDTH{1'b0}});
    sh  = SHR_WIDTH'(adj >>> FRAC_BITS);
    if (sh > SHR_WIDTH'(CMAX)) begin
      r = CMAX;
    end else if (sh < $signed({{(SHR_WIDTH-COORD_WIDTH){1'b1}}, CMIN})) begin
      r = CMIN;
    end else begin
      r = sh[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

  // one restoring-division step on a 33-bit remainder
  function automatic logic [COORD_WIDTH+1:0] div_bit(logic [COORD_WIDTH:0] rem,
                                                     logic [COORD_WIDTH-1:0] span,
                                                     logic shift);
    logic [COORD_WIDTH:0] r;
    logic                 ge;
    r  = shift ? {rem[COORD_WIDTH-1:0], 1'b0} : rem;
    ge = (r >= {1'b0, span});
    return {ge, (ge ? r - {1'b0, span} : r)};
  endfunction

  function automatic div_t div_step(div_t d, logic shift);
    div_t r;
    logic [COORD_WIDTH+1:0] bu;
    logic [COORD_WIDTH+1:0] bv;
    r  = d;
    bu = div_bit(d.rem_u, d.span_u, shift);
    bv = div_bit(d.rem_v, d.span_v, shift);
    r.rem_u = bu[COORD_WIDTH:0];
    r.rem_v = bv[COORD_WIDTH:0];
    r.q_u   = {d.q_u[UV_WIDTH-2:0], bu[COORD_WIDTH+1]};
    r.q_v   = {d.q_v[UV_WIDTH-2:0], bv[COORD_WIDTH+1]};
    return r;
  endfunction

endpackage

// ===== design/rari_if.sv =====
`timescale 1ns / 1ps

interface rari_in_if;
  logic             valid;
  logic             ready;
  rari_pkg::coord_t origin_x;
  rari_pkg::coord_t origin_y;
  rari_pkg::coord_t origin_z;
  rari_pkg::coord_t dir_x;
  rari_pkg::coord_t dir_y;
  rari_pkg::coord_t dir_z;
  rari_pkg::coord_t inv_dir_x;
  rari_pkg::coord_t inv_dir_y;
  rari_pkg::coord_t inv_dir_z;
  rari_pkg::coord_t t_lower;
  rari_pkg::coord_t t_upper;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  inv_dir_x, inv_dir_y, inv_dir_z, t_lower, t_upper, input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  inv_dir_x, inv_dir_y, inv_dir_z, t_lower, t_upper, output ready);
endinterface

interface rari_out_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  rari_pkg::coord_t                t_hit;
  logic [rari_pkg::UV_WIDTH-1:0]   u_coord;
  logic [rari_pkg::UV_WIDTH-1:0]   v_coord;
  logic                            normal_negative;
  rari_pkg::coord_t                point_x;
  rari_pkg::coord_t                point_y;
  rari_pkg::coord_t                point_z;

  modport source (output valid, hit, t_hit, u_coord, v_coord, normal_negative,
                  point_x, point_y, point_z, input ready);
  modport sink   (input valid, hit, t_hit, u_coord, v_coord, normal_negative,
                  point_x, point_y, point_z, output ready);
endinterface

interface rari_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rari_pkg::CFG_IDX_W-1:0]    index;
  logic [rari_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/ray_axis_rect_intersect_core.sv =====
`timescale 1ns / 1ps

// Channel | Dir | Payload                                          | Transaction
// in_if   | in  | origin, dir, inv_dir (xyz), t_lower, t_upper     | valid & ready
// out_if  | out | hit, t_hit, u/v_coord, normal_negative, point xyz| valid & ready
// cfg_if  | in  | index (3b), data (32b)                           | valid & ready
//
// 24-stage pipeline, one ray per cycle when out_if does not stall. Depth is
// set by the 17-step restoring divider that produces u and v (one quotient bit
// per stage, both coordinates in parallel).
// rst_n is synchronous: it empties the pipeline and loads register defaults.
// Each stage holds its item until the next stage has room, so a stall at
// out_if squeezes out bubbles and loses or repeats no transaction.
// cfg_if is always ready; registers are read live by the pipeline.

module ray_axis_rect_intersect_core (
  input  logic         clk,
  input  logic         rst_n,
  rari_in_if.sink      in_if,
  rari_out_if.source   out_if,
  rari_cfg_if.sink     cfg_if
);

  typedef struct packed {
    logic             mode_ok;
    logic             dn_nonneg;
    rari_pkg::coord_t diff;
    rari_pkg::coord_t ivn;
    rari_pkg::coord_t oa;
    rari_pkg::coord_t ob;
    rari_pkg::coord_t da;
    rari_pkg::coord_t db;
    rari_pkg::coord_t tl;
    rari_pkg::coord_t tu;
  } s1_t;

  typedef struct packed {
    logic                                    mode_ok;
    logic                                    dn_nonneg;
    logic signed [rari_pkg::PROD_WIDTH-1:0]  prod;
    rari_pkg::coord_t                        oa;
    rari_pkg::coord_t                        ob;
    rari_pkg::coord_t                        da;
    rari_pkg::coord_t                        db;
    rari_pkg::coord_t                        tl;
    rari_pkg::coord_t                        tu;
  } s2_t;

  typedef struct packed {
    logic             ok;
    logic             dn_nonneg;
    rari_pkg::coord_t t;
    rari_pkg::coord_t oa;
    rari_pkg::coord_t ob;
    rari_pkg::coord_t da;
    rari_pkg::coord_t db;
  } s3_t;

  typedef struct packed {
    logic                                    ok;
    logic                                    dn_nonneg;
    rari_pkg::coord_t                        t;
    rari_pkg::coord_t                        oa;
    rari_pkg::coord_t                        ob;
    logic signed [rari_pkg::PROD_WIDTH-1:0]  prod_a;
    logic signed [rari_pkg::PROD_WIDTH-1:0]  prod_b;
  } s4_t;

  typedef struct packed {
    logic             ok;
    logic             dn_nonneg;
    rari_pkg::coord_t t;
    rari_pkg::coord_t pa;
    rari_pkg::coord_t pb;
  } s5_t;

  typedef struct packed {
    logic                            hit;
    rari_pkg::coord_t                t_hit;
    logic [rari_pkg::UV_WIDTH-1:0]   u_coord;
    logic [rari_pkg::UV_WIDTH-1:0]   v_coord;
    logic                            normal_negative;
    rari_pkg::coord_t                point_x;
    rari_pkg::coord_t                point_y;
    rari_pkg::coord_t                point_z;
  } out_t;

  // configuration registers
  logic [1:0]       mode_r;
  rari_pkg::coord_t off_r;
  rari_pkg::coord_t la_r;
  rari_pkg::coord_t ha_r;
  rari_pkg::coord_t lb_r;
  rari_pkg::coord_t hb_r;
  logic             rev_r;
  logic             two_r;

  logic [rari_pkg::NUM_ST-1:0] vld_r;
  logic [rari_pkg::NUM_ST-1:0] adv;

  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  s4_t  s4_r, s4_nxt;
  s5_t  s5_r, s5_nxt;
  rari_pkg::div_t div_r [0:rari_pkg::DIV_LAST];
  rari_pkg::div_t div0_nxt;
  out_t out_r, out_nxt;

  // ---------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rari_pkg::MODE_XY;
      off_r  <= '0;
      la_r   <= '0;
      ha_r   <= rari_pkg::COORD_WIDTH'(65536);
      lb_r   <= '0;
      hb_r   <= rari_pkg::COORD_WIDTH'(65536);
      rev_r  <= 1'b0;
      two_r  <= 1'b0;
    end else if (cfg_if.valid) begin
      unique case (rari_pkg::reg_idx_t'(cfg_if.index))
        rari_pkg::REG_PLANE_MODE:   mode_r <= cfg_if.data[1:0];
        rari_pkg::REG_PLANE_OFFSET: off_r  <= cfg_if.data;
        rari_pkg::REG_LOW_A:        la_r   <= cfg_if.data;
        rari_pkg::REG_HIGH_A:       ha_r   <= cfg_if.data;
        rari_pkg::REG_LOW_B:        lb_r   <= cfg_if.data;
        rari_pkg::REG_HIGH_B:       hb_r   <= cfg_if.data;
        rari_pkg::REG_REVERSE:      rev_r  <= cfg_if.data[0];
        rari_pkg::REG_TWO_SIDED:    two_r  <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // flow control: a stage takes new data when it is empty or drains
  // ---------------------------------------------------------------------
  always_comb begin
    adv[rari_pkg::NUM_ST-1] = !vld_r[rari_pkg::NUM_ST-1] || out_if.ready;
    for (int k = rari_pkg::NUM_ST - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_if.ready = adv[rari_pkg::ST_S1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_if.valid;
      end
      for (int k = 1; k < rari_pkg::NUM_ST; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // S1: select axes by plane, offset minus origin on the normal axis
  // ---------------------------------------------------------------------
  always_comb begin
    rari_pkg::coord_t on;
    rari_pkg::coord_t dn;
    s1_nxt         = '0;
    on             = '0;
    dn             = '0;
    s1_nxt.mode_ok = 1'b1;
    s1_nxt.tl      = in_if.t_lower;
    s1_nxt.tu      = in_if.t_upper;
    unique case (mode_r)
      rari_pkg::MODE_XY: begin
        on = in_if.origin_z; dn = in_if.dir_z; s1_nxt.ivn = in_if.inv_dir_z;
        s1_nxt.oa = in_if.origin_x; s1_nxt.da = in_if.dir_x;
        s1_nxt.ob = in_if.origin_y; s1_nxt.db = in_if.dir_y;
      end
      rari_pkg::MODE_XZ: begin
        on = in_if.origin_y; dn = in_if.dir_y; s1_nxt.ivn = in_if.inv_dir_y;
        s1_nxt.oa = in_if.origin_x; s1_nxt.da = in_if.dir_x;
        s1_nxt.ob = in_if.origin_z; s1_nxt.db = in_if.dir_z;
      end
      rari_pkg::MODE_YZ: begin
        on = in_if.origin_x; dn = in_if.dir_x; s1_nxt.ivn = in_if.inv_dir_x;
        s1_nxt.oa = in_if.origin_z; s1_nxt.da = in_if.dir_z;
        s1_nxt.ob = in_if.origin_y; s1_nxt.db = in_if.dir_y;
      end
      default: begin
        s1_nxt.mode_ok = 1'b0;   // unused plane code: always a miss
      end
    endcase
    s1_nxt.diff      = rari_pkg::sat_sub(off_r, on);
    s1_nxt.dn_nonneg = !dn[rari_pkg::COORD_WIDTH-1];
  end

  // S2: t product
  always_comb begin
    s2_nxt.mode_ok   = s1_r.mode_ok;
    s2_nxt.dn_nonneg = s1_r.dn_nonneg;
    s2_nxt.prod      = rari_pkg::PROD_WIDTH'(s1_r.diff) * rari_pkg::PROD_WIDTH'(s1_r.ivn);
    s2_nxt.oa        = s1_r.oa;
    s2_nxt.ob        = s1_r.ob;
    s2_nxt.da        = s1_r.da;
    s2_nxt.db        = s1_r.db;
    s2_nxt.tl        = s1_r.tl;
    s2_nxt.tu        = s1_r.tu;
  end

  // S3: rescale t, check the window
  always_comb begin
    rari_pkg::coord_t t;
    t                = rari_pkg::qsat(s2_r.prod);
    s3_nxt.t         = t;
    s3_nxt.ok        = s2_r.mode_ok && (t >= s2_r.tl) && (t <= s2_r.tu);
    s3_nxt.dn_nonneg = s2_r.dn_nonneg;
    s3_nxt.oa        = s2_r.oa;
    s3_nxt.ob        = s2_r.ob;
    s3_nxt.da        = s2_r.da;
    s3_nxt.db        = s2_r.db;
  end

  // S4: in-plane products t*da, t*db
  always_comb begin
    s4_nxt.ok        = s3_r.ok;
    s4_nxt.dn_nonneg = s3_r.dn_nonneg;
    s4_nxt.t         = s3_r.t;
    s4_nxt.oa        = s3_r.oa;
    s4_nxt.ob        = s3_r.ob;
    s4_nxt.prod_a    = rari_pkg::PROD_WIDTH'(s3_r.t) * rari_pkg::PROD_WIDTH'(s3_r.da);
    s4_nxt.prod_b    = rari_pkg::PROD_WIDTH'(s3_r.t) * rari_pkg::PROD_WIDTH'(s3_r.db);
  end

  // S5: hit coordinates a and b
  always_comb begin
    s5_nxt.ok        = s4_r.ok;
    s5_nxt.dn_nonneg = s4_r.dn_nonneg;
    s5_nxt.t         = s4_r.t;
    s5_nxt.pa        = rari_pkg::sat_add(s4_r.oa, rari_pkg::qsat(s4_r.prod_a));
    s5_nxt.pb        = rari_pkg::sat_add(s4_r.ob, rari_pkg::qsat(s4_r.prod_b));
  end

  // divider setup: bounds test, numerator and span for u and v
  always_comb begin
    logic signed [rari_pkg::COORD_WIDTH:0] nu, nv, su, sv;
    nu = {s5_r.pa[rari_pkg::COORD_WIDTH-1], s5_r.pa} - {la_r[rari_pkg::COORD_WIDTH-1], la_r};
    nv = {s5_r.pb[rari_pkg::COORD_WIDTH-1], s5_r.pb} - {lb_r[rari_pkg::COORD_WIDTH-1], lb_r};
    su = {ha_r[rari_pkg::COORD_WIDTH-1], ha_r} - {la_r[rari_pkg::COORD_WIDTH-1], la_r};
    sv = {hb_r[rari_pkg::COORD_WIDTH-1], hb_r} - {lb_r[rari_pkg::COORD_WIDTH-1], lb_r};
    div0_nxt.hit = s5_r.ok && (s5_r.pa >= la_r) && (s5_r.pa <= ha_r)
                   && (s5_r.pb >= lb_r) && (s5_r.pb <= hb_r);
    div0_nxt.t         = s5_r.t;
    div0_nxt.pa        = s5_r.pa;
    div0_nxt.pb        = s5_r.pb;
    div0_nxt.dn_nonneg = s5_r.dn_nonneg;
    // on a hit the numerator never exceeds the span, so 32 bits hold both
    div0_nxt.rem_u     = {1'b0, nu[rari_pkg::COORD_WIDTH-1:0]};
    div0_nxt.rem_v     = {1'b0, nv[rari_pkg::COORD_WIDTH-1:0]};
    div0_nxt.span_u    = su[rari_pkg::COORD_WIDTH-1:0];
    div0_nxt.span_v    = sv[rari_pkg::COORD_WIDTH-1:0];
    div0_nxt.q_u       = '0;
    div0_nxt.q_v       = '0;
  end

  // output stage: flips, normal, point assembly, zero on miss
  always_comb begin
    rari_pkg::div_t         d;
    logic [rari_pkg::UV_WIDTH-1:0] u;
    logic [rari_pkg::UV_WIDTH-1:0] v;
    d = div_r[rari_pkg::DIV_LAST];
    u = (d.span_u == '0) ? '0 : d.q_u;   // empty span reads as zero
    v = (d.span_v == '0) ? '0 : d.q_v;
    if (mode_r != rari_pkg::MODE_XY) begin
      u = rari_pkg::UV_ONE - u;
    end
    if (rev_r) begin
      u = rari_pkg::UV_ONE - u;
    end
    out_nxt = '0;
    if (d.hit) begin
      out_nxt.hit             = 1'b1;
      out_nxt.t_hit           = d.t;
      out_nxt.u_coord         = u;
      out_nxt.v_coord         = v;
      out_nxt.normal_negative = two_r ? d.dn_nonneg : rev_r;
      unique case (mode_r)
        rari_pkg::MODE_XY: begin
          out_nxt.point_x = d.pa; out_nxt.point_y = d.pb; out_nxt.point_z = off_r;
        end
        rari_pkg::MODE_XZ: begin
          out_nxt.point_x = d.pa; out_nxt.point_y = off_r; out_nxt.point_z = d.pb;
        end
        default: begin
          out_nxt.point_x = off_r; out_nxt.point_y = d.pb; out_nxt.point_z = d.pa;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv[rari_pkg::ST_S1]) s1_r <= s1_nxt;
    if (adv[rari_pkg::ST_S2]) s2_r <= s2_nxt;
    if (adv[rari_pkg::ST_S3]) s3_r <= s3_nxt;
    if (adv[rari_pkg::ST_S4]) s4_r <= s4_nxt;
    if (adv[rari_pkg::ST_S5]) s5_r <= s5_nxt;
    if (adv[rari_pkg::ST_DIV0]) div_r[0] <= div0_nxt;
    // first step yields the integer bit (numerator == span), no shift
    for (int k = 1; k <= rari_pkg::DIV_LAST; k++) begin
      if (adv[rari_pkg::ST_DIV0 + k]) begin
        div_r[k] <= rari_pkg::div_step(div_r[k-1], (k != 1));
      end
    end
    if (adv[rari_pkg::ST_OUT]) out_r <= out_nxt;
  end

  assign out_if.valid           = vld_r[rari_pkg::ST_OUT];
  assign out_if.hit             = out_r.hit;
  assign out_if.t_hit           = out_r.t_hit;
  assign out_if.u_coord         = out_r.u_coord;
  assign out_if.v_coord         = out_r.v_coord;
  assign out_if.normal_negative = out_r.normal_negative;
  assign out_if.point_x         = out_r.point_x;
  assign out_if.point_y         = out_r.point_y;
  assign out_if.point_z         = out_r.point_z;

endmodule

// ===== design/rari_checker.sv =====
`timescale 1ns / 1ps

module rari_props (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          hit,
  input rari_pkg::coord_t              t_hit,
  input logic [rari_pkg::UV_WIDTH-1:0] u_coord,
  input logic [rari_pkg::UV_WIDTH-1:0] v_coord,
  input logic                          normal_negative,
  input rari_pkg::coord_t              point_x
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(t_hit) && $stable(u_coord))
    else $error("stalled result changed");

  // miss carries zero t_hit, u_coord, v_coord, normal_negative and point_x
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !hit |-> t_hit == '0 && u_coord == '0 && v_coord == '0
                          && !normal_negative && point_x == '0)
    else $error("miss with nonzero fields");

  // surface coordinates stay within one
  a_uv_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && hit |-> u_coord <= rari_pkg::UV_ONE && v_coord <= rari_pkg::UV_ONE)
    else $error("uv out of range");

endmodule

bind ray_axis_rect_intersect_core rari_props u_rari_props (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .hit             (out_if.hit),
  .t_hit           (out_if.t_hit),
  .u_coord         (out_if.u_coord),
  .v_coord         (out_if.v_coord),
  .normal_negative (out_if.normal_negative),
  .point_x         (out_if.point_x)
);

// ===== bench/rari_checker.sv =====
`timescale 1ns / 1ps

module rari_checker
  import rari_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  rari_in_if    in_mon,
  rari_out_if   out_mon,
  rari_cfg_if   cfg_mon,
  output int    fail_count,
  output int    pending,
  output int    n_rays,
  output int    n_results,
  output int    n_hits
);

  typedef struct {
    logic                hit;
    coord_t              t_hit;
    logic [UV_WIDTH-1:0] u;
    logic [UV_WIDTH-1:0] v;
    logic                nneg;
    coord_t              px;
    coord_t              py;
    coord_t              pz;
  } hit_rec_t;

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  // shadow copy of the live registers
  logic [1:0] sh_mode;
  longint     sh_off, sh_la, sh_ha, sh_lb, sh_hb;
  logic       sh_rev, sh_two;

  hit_rec_t expected_hits[$];

  function automatic longint clamp_q(longint x);
    if (x > QMAX) return QMAX;
    if (x < QMIN) return QMIN;
    return x;
  endfunction

  // Q16.16 product, truncated toward zero, then saturated
  function automatic longint fx_mul(longint a, longint b);
    longint p;
    longint m;
    p = a * b;
    if (p < 0) m = -((-p) >>> FRAC_BITS);
    else m = p >>> FRAC_BITS;
    return clamp_q(m);
  endfunction

  function automatic longint span_frac(longint p, longint lo, longint hi);
    longint span;
    longint r;
    span = hi - lo;
    if (span == 0) return 0;
    r = ((p - lo) * 65536) / span;
    return (r > 65536) ? 65536 : r;
  endfunction

  function automatic hit_rec_t intersect_ray();
    hit_rec_t r;
    longint o[3], d[3], iv[3];
    longint tl, tu, t, pa, pb, u, v;
    longint pt[3];
    int n, ia, ib;
    r = '{default: '0};
    o[0] = in_mon.origin_x;  o[1] = in_mon.origin_y;  o[2] = in_mon.origin_z;
    d[0] = in_mon.dir_x;     d[1] = in_mon.dir_y;     d[2] = in_mon.dir_z;
    iv[0] = in_mon.inv_dir_x; iv[1] = in_mon.inv_dir_y; iv[2] = in_mon.inv_dir_z;
    tl = in_mon.t_lower;
    tu = in_mon.t_upper;
    case (sh_mode)
      MODE_XY: begin n = 2; ia = 0; ib = 1; end
      MODE_XZ: begin n = 1; ia = 0; ib = 2; end
      MODE_YZ: begin n = 0; ia = 2; ib = 1; end
      default: return r;
    endcase
    t = fx_mul(clamp_q(sh_off - o[n]), iv[n]);
    if (t < tl || t > tu) return r;
    pa = clamp_q(o[ia] + fx_mul(t, d[ia]));
    pb = clamp_q(o[ib] + fx_mul(t, d[ib]));
    if (pa < sh_la || pa > sh_ha || pb < sh_lb || pb > sh_hb) return r;
    u = span_frac(pa, sh_la, sh_ha);
    v = span_frac(pb, sh_lb, sh_hb);
    if (sh_mode != MODE_XY) u = 65536 - u;
    if (sh_rev) u = 65536 - u;
    pt[n] = sh_off;
    pt[ia] = pa;
    pt[ib] = pb;
    r.hit = 1'b1;
    r.t_hit = coord_t'(t);
    r.u = UV_WIDTH'(u);
    r.v = UV_WIDTH'(v);
    r.nneg = sh_two ? (d[n] >= 0) : sh_rev;
    r.px = coord_t'(pt[0]);
    r.py = coord_t'(pt[1]);
    r.pz = coord_t'(pt[2]);
    return r;
  endfunction

  assign pending = expected_hits.size();

  always @(posedge clk) begin
    hit_rec_t e;
    if (!rst_n) begin
      sh_mode <= MODE_XY;
      sh_off <= 0; sh_la <= 0; sh_ha <= 65536; sh_lb <= 0; sh_hb <= 65536;
      sh_rev <= 1'b0; sh_two <= 1'b0;
      expected_hits.delete();
      fail_count <= 0; n_rays <= 0; n_results <= 0; n_hits <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (reg_idx_t'(cfg_mon.index))
          REG_PLANE_MODE:   sh_mode <= cfg_mon.data[1:0];
          REG_PLANE_OFFSET: sh_off <= longint'($signed(cfg_mon.data));
          REG_LOW_A:        sh_la <= longint'($signed(cfg_mon.data));
          REG_HIGH_A:       sh_ha <= longint'($signed(cfg_mon.data));
          REG_LOW_B:        sh_lb <= longint'($signed(cfg_mon.data));
          REG_HIGH_B:       sh_hb <= longint'($signed(cfg_mon.data));
          REG_REVERSE:      sh_rev <= cfg_mon.data[0];
          REG_TWO_SIDED:    sh_two <= cfg_mon.data[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_hits.push_back(intersect_ray());
        n_rays <= n_rays + 1;
      end
      if (out_mon.valid && out_mon.ready) begin
        n_results <= n_results + 1;
        if (expected_hits.size() == 0) begin
          $error("result with no ray outstanding");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_hits.pop_front();
          if (e.hit) n_hits <= n_hits + 1;
          if (out_mon.hit !== e.hit ||
              out_mon.t_hit !== e.t_hit ||
              out_mon.u_coord !== e.u ||
              out_mon.v_coord !== e.v ||
              out_mon.normal_negative !== e.nneg ||
              out_mon.point_x !== e.px ||
              out_mon.point_y !== e.py ||
              out_mon.point_z !== e.pz)
            fail_count <= fail_count + 1;
          if (out_mon.hit !== e.hit)
            $error("hit: expected %0d, got %0d", e.hit, out_mon.hit);
          if (out_mon.t_hit !== e.t_hit)
            $error("t_hit: expected %0d, got %0d", e.t_hit, out_mon.t_hit);
          if (out_mon.u_coord !== e.u)
            $error("u_coord: expected %0d, got %0d", e.u, out_mon.u_coord);
          if (out_mon.v_coord !== e.v)
            $error("v_coord: expected %0d, got %0d", e.v, out_mon.v_coord);
          if (out_mon.normal_negative !== e.nneg)
            $error("normal_negative: expected %0d, got %0d", e.nneg,
                   out_mon.normal_negative);
          if (out_mon.point_x !== e.px)
            $error("point_x: expected %0d, got %0d", e.px, out_mon.point_x);
          if (out_mon.point_y !== e.py)
            $error("point_y: expected %0d, got %0d", e.py, out_mon.point_y);
          if (out_mon.point_z !== e.pz)
            $error("point_z: expected %0d, got %0d", e.pz, out_mon.point_z);
        end
      end
    end
  end

endmodule

// ===== bench/tb_ray_axis_rect_intersect_core.sv =====
`timescale 1ns / 1ps

module tb_ray_axis_rect_intersect_core;
  import rari_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 40;    // pipeline is 24 deep
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int IDLE_LIMIT   = 5000;  // watchdog: cycles without any transaction

  typedef struct {
    coord_t o[3];
    coord_t d[3];
    coord_t iv[3];
    coord_t tl;
    coord_t tu;
  } ray_t;

  logic clk;
  logic rst_n;

  rari_in_if  in_if();
  rari_out_if out_if();
  rari_cfg_if cfg_if();

  int fail_count, pending, n_rays, n_results, n_hits;

  ray_axis_rect_intersect_core dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if)
  );

  rari_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_if), .out_mon(out_if), .cfg_mon(cfg_if),
    .fail_count(fail_count), .pending(pending), .n_rays(n_rays),
    .n_results(n_results), .n_hits(n_hits)
  );

  // stimulus-side copy of the rectangle, used only to aim rays
  logic [1:0] aim_mode;
  longint     aim_off, aim_la, aim_ha, aim_lb, aim_hb;
  int         burst_left;
  int         hold_requests;
  int         phases_run;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: its own rotating stall pattern, plus a long hold-off on request
  // so the pipeline fills and back-pressures the sender.
  initial begin
    int served;
    int cyc;
    int style;
    served = 0;
    cyc = 0;
    style = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 97 == 0) style = $urandom_range(0, 3);
      if (hold_requests > served) begin
        served++;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case (style)
          0: out_if.ready <= 1'b1;                            // no stalls
          1: out_if.ready <= ($urandom_range(0, 1) == 0);
          2: out_if.ready <= ($urandom_range(0, 9) != 0);
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog: any transaction on any channel resets the count
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready) || !rst_n)
        idle = 0;
      else
        idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("watchdog: %0d idle cycles, %0d results outstanding", idle, pending);
        $display("ray_axis_rect_intersect_core test failed");
        $finish;
      end
    end
  end

  function automatic longint clamp_q(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint rand_signed(int mag);
    return longint'($urandom_range(0, 2 * mag)) - mag;
  endfunction

  function automatic longint pick_in(longint lo, longint hi);
    longint span;
    if (hi <= lo) return lo + rand_signed(4096);
    span = hi - lo;
    // favor exact edges now and then
    case ($urandom_range(0, 9))
      0: return lo;
      1: return hi;
      default: return lo + ((longint'($urandom) << 16 | $urandom_range(0, 65535)) % (span + 1));
    endcase
  endfunction

  // Noise: every bit of every field random
  function automatic ray_t noise_ray();
    ray_t r;
    for (int i = 0; i < 3; i++) begin
      r.o[i] = $urandom; r.d[i] = $urandom; r.iv[i] = $urandom;
    end
    r.tl = $urandom;
    r.tu = $urandom;
    return r;
  endfunction

  // Ray aimed at a point of the current rectangle (inside, on edge, or just off)
  function automatic ray_t aimed_ray();
    ray_t r;
    longint t, a, b, dn, dl;
    int n, ia, ib;
    case (aim_mode)
      MODE_XZ: begin n = 1; ia = 0; ib = 2; end
      MODE_YZ: begin n = 0; ia = 2; ib = 1; end
      default: begin n = 2; ia = 0; ib = 1; end
    endcase
    t = longint'($urandom_range(1, 8)) * 65536 + $urandom_range(0, 65535);
    if ($urandom_range(0, 7) == 0) t = -t;
    a = pick_in(aim_la, aim_ha);
    b = pick_in(aim_lb, aim_hb);
    if ($urandom_range(0, 9) == 0) a = a + rand_signed(8192);
    if ($urandom_range(0, 9) == 0) b = b + rand_signed(8192);
    dn = rand_signed(4 * 65536);
    if (dn > -4096 && dn < 4096) dn = (dn < 0) ? -4096 : 4096;
    r.d[n] = coord_t'(dn);
    r.d[ia] = coord_t'(rand_signed(4 * 65536));
    r.d[ib] = coord_t'(rand_signed(4 * 65536));
    r.iv[n] = coord_t'(clamp_q((64'sd1 << 32) / dn));
    r.iv[ia] = $urandom;
    r.iv[ib] = $urandom;
    if ($urandom_range(0, 19) == 0) begin
      // parallel ray: zero normal component, saturated reciprocal
      r.d[n] = '0;
      r.iv[n] = $urandom_range(0, 1) ? CMAX : CMIN;
    end
    r.o[n] = coord_t'(clamp_q(aim_off - ((t * dn) >>> 16)));
    r.o[ia] = coord_t'(clamp_q(a - ((t * longint'(r.d[ia])) >>> 16)));
    r.o[ib] = coord_t'(clamp_q(b - ((t * longint'(r.d[ib])) >>> 16)));
    case ($urandom_range(0, 5))
      0: begin r.tl = CMIN; r.tu = CMAX; end
      1: begin r.tl = coord_t'(t); r.tu = coord_t'(t); end
      2: begin r.tl = coord_t'(t + 256); r.tu = CMAX; end  // window past t
      default: begin
        dl = $urandom_range(0, 65536);
        r.tl = coord_t'(clamp_q(t - dl - 256));
        r.tu = coord_t'(clamp_q(t + $urandom_range(256, 65536)));
      end
    endcase
    return r;
  endfunction

  // Drive one ray; sender works in bursts with random gaps
  task automatic send_ray(ray_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_if.origin_x <= r.o[0];  in_if.origin_y <= r.o[1];  in_if.origin_z <= r.o[2];
    in_if.dir_x <= r.d[0];     in_if.dir_y <= r.d[1];     in_if.dir_z <= r.d[2];
    in_if.inv_dir_x <= r.iv[0]; in_if.inv_dir_y <= r.iv[1]; in_if.inv_dir_z <= r.iv[2];
    in_if.t_lower <= r.tl;
    in_if.t_upper <= r.tu;
    in_if.valid <= 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_if.index <= idx;
    cfg_if.data <= value;
    cfg_if.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Registers are read live by the pipeline: only touch them when drained
  task automatic drain();
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_rect(logic [1:0] mode, longint off, longint la, longint ha,
                          longint lb, longint hb, logic rev, logic two);
    drain();
    write_reg(REG_PLANE_MODE, {30'd0, mode});
    write_reg(REG_PLANE_OFFSET, off[31:0]);
    write_reg(REG_LOW_A, la[31:0]);
    write_reg(REG_HIGH_A, ha[31:0]);
    write_reg(REG_LOW_B, lb[31:0]);
    write_reg(REG_HIGH_B, hb[31:0]);
    write_reg(REG_REVERSE, {31'd0, rev});
    write_reg(REG_TWO_SIDED, {31'd0, two});
    aim_mode = mode;
    aim_off = off; aim_la = la; aim_ha = ha; aim_lb = lb; aim_hb = hb;
    phases_run++;
  endtask

  task automatic random_rays(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 15) send_ray(noise_ray());
      else send_ray(aimed_ray());
    end
  endtask

  // Ray straight down z onto the default unit square at (x, y)
  function automatic ray_t down_z(longint x, longint y);
    ray_t r;
    r.o[0] = coord_t'(x); r.o[1] = coord_t'(y); r.o[2] = 32'sd65536;
    r.d[0] = '0; r.d[1] = '0; r.d[2] = -32'sd65536;
    r.iv[0] = CMAX; r.iv[1] = CMAX; r.iv[2] = -32'sd65536;
    r.tl = '0;
    r.tu = CMAX;
    return r;
  endfunction

  initial begin
    ray_t r;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.origin_x <= '0; in_if.origin_y <= '0; in_if.origin_z <= '0;
    in_if.dir_x <= '0; in_if.dir_y <= '0; in_if.dir_z <= '0;
    in_if.inv_dir_x <= '0; in_if.inv_dir_y <= '0; in_if.inv_dir_z <= '0;
    in_if.t_lower <= '0; in_if.t_upper <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_PLANE_MODE;
    cfg_if.data <= '0;
    burst_left = 0;
    hold_requests = 0;
    phases_run = 0;
    aim_mode = MODE_XY;
    aim_off = 0; aim_la = 0; aim_ha = 65536; aim_lb = 0; aim_hb = 65536;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset-default rectangle: corners, center, just outside,
    // window edges, parallel ray, all-zero and all-extreme fields
    send_ray(down_z(0, 0));
    send_ray(down_z(65536, 65536));
    send_ray(down_z(32768, 16384));
    send_ray(down_z(65537, 0));
    send_ray(down_z(-1, 65536));
    r = down_z(16384, 16384); r.tl = 32'sd65536; r.tu = 32'sd65536;
    send_ray(r);                                     // t exactly on both limits
    r.tl = 32'sd65537;
    send_ray(r);                                     // t below window
    r = down_z(16384, 16384); r.o[2] = -32'sd65536; r.d[2] = 32'sd65536;
    r.iv[2] = 32'sd65536;
    send_ray(r);                                     // from below, dir_n positive
    r = down_z(16384, 16384); r.d[2] = '0; r.iv[2] = CMAX;
    send_ray(r);                                     // parallel ray
    r = down_z(0, 0); r.iv[2] = CMIN; r.tl = CMIN;
    send_ray(r);                                     // saturated t
    for (int i = 0; i < 3; i++) begin
      r.o[i] = '0; r.d[i] = '0; r.iv[i] = '0;
    end
    r.tl = '0; r.tu = '0;
    send_ray(r);
    for (int i = 0; i < 3; i++) begin
      r.o[i] = CMAX; r.d[i] = CMAX; r.iv[i] = CMAX;
    end
    r.tl = CMIN; r.tu = CMAX;
    send_ray(r);
    for (int i = 0; i < 3; i++) begin
      r.o[i] = CMIN; r.d[i] = CMIN; r.iv[i] = CMIN;
    end
    send_ray(r);
    random_rays(70);

    // Each plane, both orientations and both sidedness settings
    set_rect(MODE_XY, 32'sh0002_0000, -32'sh0003_0000, 32'sh0005_0000,
             -32'sh0001_0000, 32'sh0004_0000, 1'b0, 1'b1);
    random_rays(140);

    set_rect(MODE_XZ, -32'sh0001_8000, -32'sh0000_4000, 32'sh0002_0000,
             32'sh0001_0000, 32'sh0003_0000, 1'b1, 1'b0);
    hold_requests++;                                 // fill the pipeline
    random_rays(140);

    set_rect(MODE_YZ, 32'sh0007_1234, -32'sh0010_0000, -32'sh0008_0000,
             32'sh0000_0100, 32'sh0000_0200, 1'b1, 1'b1);
    random_rays(140);

    // Unused plane code: always a miss
    set_rect(MODE_UNUSED, 0, 0, 65536, 0, 65536, 1'b0, 1'b0);
    random_rays(40);

    // Empty span on a: u is zero before the flips
    set_rect(MODE_XY, -32'sh0000_8000, 32'sh0001_0000, 32'sh0001_0000,
             0, 32'sh0002_0000, 1'b1, 1'b0);
    random_rays(80);

    // High bound below low bound: every ray misses
    set_rect(MODE_XZ, 32'sh0000_4000, 0, 32'sh0001_0000,
             32'sh0002_0000, 32'sh0001_0000, 1'b0, 1'b1);
    random_rays(60);

    // Full-range bounds, offset at the top extreme
    set_rect(MODE_YZ, 32'sh7fff_ffff, -64'sd2147483648, 64'sd2147483647,
             -64'sd2147483648, 64'sd2147483647, 1'b0, 1'b1);
    random_rays(100);

    // Offset at the bottom extreme
    set_rect(MODE_XY, -64'sd2147483648, -32'sh0004_0000, 32'sh0004_0000,
             -32'sh0004_0000, 32'sh0004_0000, 1'b1, 1'b0);
    hold_requests++;
    random_rays(100);

    // A few random rectangles
    for (int p = 0; p < 3; p++) begin
      longint la, lb;
      la = rand_signed(1 << 24);
      lb = rand_signed(1 << 24);
      set_rect(2'($urandom_range(0, 2)), rand_signed(1 << 24),
               la, la + $urandom_range(1, 1 << 20),
               lb, lb + $urandom_range(1, 1 << 20),
               1'($urandom), 1'($urandom));
      random_rays(50);
    end

    drain();
    $display("%0d rays over %0d register settings (all planes, flips, empty and inverted spans)",
             n_rays, phases_run + 1);
    $display("%0d results checked, %0d of them hits", n_results, n_hits);
    if (fail_count == 0 && pending == 0)
      $display("ray_axis_rect_intersect_core test passed");
    else
      $display("ray_axis_rect_intersect_core test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rari_pkg.sv
design/rari_if.sv
design/ray_axis_rect_intersect_core.sv
design/rari_checker.sv
bench/rari_checker.sv
bench/tb_ray_axis_rect_intersect_core.sv
